@@ rtl/core/bounded_linked_list_engine_unit_macros.svh @@
// Assertion helpers.
`ifndef BOUNDED_LINKED_LIST_ENGINE_UNIT_MACROS_SVH
`define BOUNDED_LINKED_LIST_ENGINE_UNIT_MACROS_SVH

`define BLL_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

`define BLL_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

@@ rtl/core/bll_pkg.sv @@
`default_nettype none
package bll_pkg;

  localparam int unsigned CapacityDefault   = 16;
  localparam int unsigned ValueWidthDefault = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_CONTAINS   = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_REVERSE    = 3'd5,
    OP_CLEAR      = 3'd6,
    OP_NOP        = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_code_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] operand_value;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [4:0]  occupancy;
    logic [31:0] front_value;
    logic [31:0] back_value;
  } result_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_PUSH,
    S_WALKRD,
    S_WALKCHK,
    S_RMFREE,
    S_REVRD,
    S_REVWR,
    S_CLEAR,
    S_FRONTRD,
    S_BACKRD,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load_req;
    logic init_start;
    logic init_step;   // link[addr] = addr + 1 (0 at the last slot) during the sweep
    logic rd_free;
    logic rd_cur;
    logic rd_head;
    logic rd_tail;
    logic walk_start;  // cur = head, prev = head, n = 0
    logic walk_adv;    // prev = cur, cur = link[cur], n++
    logic do_push;
    logic do_pop_head; // unlink head (pop or remove at head)
    logic rm_link;     // link[prev] = link[cur]
    logic rm_free;     // link[cur] = free head, free head = cur
    logic rev_start;
    logic rev_step;
    logic rev_finish;
    logic set_miss;
    logic set_done;
    logic set_full;
    logic cap_front;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    empty;
    logic    full;
    logic    one_left;
    logic    match;
    logic    walk_first;
    logic    walk_last;
    logic    init_last;
  } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/core/bll_datapath.sv @@
`default_nettype none
module bll_datapath #(
  parameter int unsigned CAPACITY    = bll_pkg::CapacityDefault,
  parameter int unsigned VALUE_WIDTH = bll_pkg::ValueWidthDefault
) (
  input  wire                  clk,
  input  wire                  rst,
  input  bll_pkg::request_t    req,
  input  bll_pkg::dp_cmd_t     cmd,
  output bll_pkg::dp_status_t  sts,
  output bll_pkg::result_t     res
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];
  logic [AW-1:0]          link_mem  [CAPACITY];

  bll_pkg::opcode_t       opcode;
  logic [VALUE_WIDTH-1:0] operand;
  logic [AW-1:0]          head, tail, free_head, cur, prev, init_addr;
  logic [CW-1:0]          count, walk_n;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic [AW-1:0]          rd_link;
  bll_pkg::status_code_t  status;
  logic [VALUE_WIDTH-1:0] data, front;
  bll_pkg::result_t       res_reg;

  logic          lwe, re;
  logic [AW-1:0] lwa, lwd, ra;

  always_comb begin
    lwe = 1'b0;
    lwa = init_addr;
    lwd = free_head;
    if (cmd.init_step) begin
      lwe = 1'b1;
      lwd = (init_addr == AW'(CAPACITY - 1)) ? '0 : init_addr + AW'(1);
    end else if (cmd.do_push) begin
      if (count != '0) begin
        lwe = 1'b1;
        if (opcode == bll_pkg::OP_PUSH_FRONT) begin
          lwa = free_head; lwd = head;
        end else begin
          lwa = tail; lwd = free_head;
        end
      end
    end else if (cmd.do_pop_head) begin
      lwe = 1'b1; lwa = head; lwd = free_head;
    end else if (cmd.rm_link) begin
      lwe = 1'b1; lwa = prev; lwd = rd_link;
    end else if (cmd.rm_free) begin
      lwe = 1'b1; lwa = cur; lwd = free_head;
    end else if (cmd.rev_step) begin
      lwe = (walk_n != '0); lwa = cur; lwd = prev;
    end
  end

  always_comb begin
    re = 1'b1;
    ra = cur;
    if (cmd.rd_free) ra = free_head;
    else if (cmd.rd_head) ra = head;
    else if (cmd.rd_tail) ra = tail;
    else if (!cmd.rd_cur) re = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.do_push) value_mem[free_head] <= operand;
    if (lwe) link_mem[lwa] <= lwd;
    if (re) begin
      rd_value <= value_mem[ra];
      rd_link  <= link_mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0; tail <= '0; free_head <= '0; count <= '0; init_addr <= '0;
    end else begin
      if (cmd.init_start) begin
        head <= '0; tail <= '0; free_head <= '0; count <= '0; init_addr <= '0;
      end
      if (cmd.init_step) init_addr <= init_addr + AW'(1);
      if (cmd.do_push) begin
        free_head <= rd_link;
        count     <= count + CW'(1);
        if (count == '0) begin
          head <= free_head; tail <= free_head;
        end else if (opcode == bll_pkg::OP_PUSH_FRONT) begin
          head <= free_head;
        end else begin
          tail <= free_head;
        end
      end
      if (cmd.do_pop_head) begin
        free_head <= head;
        count     <= count - CW'(1);
        if (count == CW'(1)) begin
          head <= '0; tail <= '0;
        end else begin
          head <= rd_link;
        end
      end
      if (cmd.rm_link) begin
        count <= count - CW'(1);
        if (cur == tail) tail <= prev;
      end
      if (cmd.rm_free) free_head <= cur;
      if (cmd.rev_start) tail <= head;
      if (cmd.rev_finish) head <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      opcode  <= bll_pkg::opcode_t'(req.opcode);
      operand <= VALUE_WIDTH'(req.operand_value);
      status  <= bll_pkg::ST_DONE;
      data    <= '0;
    end
    if (cmd.walk_start || cmd.rev_start) begin
      cur <= head; prev <= head; walk_n <= '0;
    end
    if (cmd.walk_adv || cmd.rev_step) begin
      prev <= cur; cur <= rd_link; walk_n <= walk_n + CW'(1);
    end
    if (cmd.set_miss) status <= bll_pkg::ST_MISS;
    if (cmd.set_done) status <= bll_pkg::ST_DONE;
    if (cmd.set_full) status <= bll_pkg::ST_FULL;
    if (cmd.do_pop_head && opcode == bll_pkg::OP_POP_FRONT) data <= rd_value;
    if (cmd.cap_front) front <= (count == '0) ? '0 : rd_value;
    if (cmd.out_load) begin
      res_reg.status      <= status;
      res_reg.data_out    <= 32'(data);
      res_reg.occupancy   <= 5'(count);
      res_reg.front_value <= 32'(front);
      res_reg.back_value  <= (count == '0) ? '0 : 32'(rd_value);
    end
  end

  assign res = res_reg;

  assign sts.opcode     = opcode;
  assign sts.empty      = (count == '0);
  assign sts.full       = (count >= CW'(CAPACITY));
  assign sts.one_left   = (count <= CW'(1));
  assign sts.match      = (rd_value == operand);
  assign sts.walk_first = (walk_n == '0);
  assign sts.walk_last  = ((walk_n + CW'(1)) >= count);
  assign sts.init_last  = (init_addr == AW'(CAPACITY - 1));

endmodule
`default_nettype wire

@@ rtl/core/bll_controller.sv @@
`default_nettype none
`include "bounded_linked_list_engine_unit_macros.svh"
module bll_controller (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire                 out_stall,
  input  bll_pkg::dp_status_t sts,
  output bll_pkg::dp_cmd_t    cmd
);

  bll_pkg::ctrl_state_t state, state_next;
  logic out_full;
  logic out_take;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bll_pkg::S_INIT;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_full <= 1'b1;
      else if (out_take) out_full <= 1'b0;
    end
  end

  assign out_valid = out_full;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      bll_pkg::S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) state_next = bll_pkg::S_IDLE;
      end
      bll_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = bll_pkg::S_DECODE;
        end
      end
      bll_pkg::S_DECODE: begin
        state_next = bll_pkg::S_FRONTRD;
        case (sts.opcode)
          bll_pkg::OP_PUSH_FRONT, bll_pkg::OP_PUSH_BACK: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
            end else begin
              cmd.rd_free = 1'b1;
              state_next  = bll_pkg::S_PUSH;
            end
          end
          bll_pkg::OP_POP_FRONT: begin
            if (sts.empty) begin
              cmd.set_miss = 1'b1;
            end else begin
              cmd.walk_start = 1'b1;
              state_next     = bll_pkg::S_WALKRD;
            end
          end
          bll_pkg::OP_CONTAINS, bll_pkg::OP_REMOVE: begin
            cmd.set_miss = 1'b1;
            if (!sts.empty) begin
              cmd.walk_start = 1'b1;
              state_next     = bll_pkg::S_WALKRD;
            end
          end
          bll_pkg::OP_REVERSE: begin
            if (!sts.one_left) begin
              cmd.rev_start = 1'b1;
              state_next    = bll_pkg::S_REVRD;
            end
          end
          bll_pkg::OP_CLEAR: begin
            cmd.init_start = 1'b1;
            state_next     = bll_pkg::S_CLEAR;
          end
          default: ;
        endcase
      end
      bll_pkg::S_PUSH: begin
        cmd.do_push = 1'b1;
        state_next  = bll_pkg::S_FRONTRD;
      end
      bll_pkg::S_WALKRD: begin
        cmd.rd_cur = 1'b1;
        state_next = bll_pkg::S_WALKCHK;
      end
      bll_pkg::S_WALKCHK: begin
        state_next = bll_pkg::S_FRONTRD;
        case (sts.opcode)
          bll_pkg::OP_POP_FRONT: cmd.do_pop_head = 1'b1;
          bll_pkg::OP_CONTAINS, bll_pkg::OP_REMOVE: begin
            if (sts.match) begin
              cmd.set_done = 1'b1;
              if (sts.opcode == bll_pkg::OP_REMOVE) begin
                if (sts.walk_first) begin
                  cmd.do_pop_head = 1'b1;
                end else begin
                  cmd.rm_link = 1'b1;
                  state_next  = bll_pkg::S_RMFREE;
                end
              end
            end else if (!sts.walk_last) begin
              cmd.walk_adv = 1'b1;
              state_next   = bll_pkg::S_WALKRD;
            end
          end
          default: ;
        endcase
      end
      bll_pkg::S_RMFREE: begin
        cmd.rm_free = 1'b1;
        state_next  = bll_pkg::S_FRONTRD;
      end
      bll_pkg::S_REVRD: begin
        cmd.rd_cur = 1'b1;
        state_next = bll_pkg::S_REVWR;
      end
      bll_pkg::S_REVWR: begin
        cmd.rev_step = 1'b1;
        if (sts.walk_last) begin
          cmd.rev_finish = 1'b1;
          state_next     = bll_pkg::S_FRONTRD;
        end else begin
          state_next = bll_pkg::S_REVRD;
        end
      end
      bll_pkg::S_CLEAR: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) state_next = bll_pkg::S_FRONTRD;
      end
      bll_pkg::S_FRONTRD: begin
        cmd.rd_head = 1'b1;
        state_next  = bll_pkg::S_BACKRD;
      end
      bll_pkg::S_BACKRD: begin
        cmd.cap_front = 1'b1;
        cmd.rd_tail   = 1'b1;
        state_next    = bll_pkg::S_OUT;
      end
      bll_pkg::S_OUT: begin
        if (!out_full || out_take) begin
          cmd.out_load = 1'b1;
          state_next   = bll_pkg::S_IDLE;
        end
      end
      default: state_next = bll_pkg::S_INIT;
    endcase
  end

  `BLL_ASSERT_IMP(a_busy_stall, clk, rst, state != bll_pkg::S_IDLE, in_stall,
    "request taken while busy")
  `BLL_ASSERT_NEXT(a_load_valid, clk, rst, cmd.out_load, out_valid,
    "result not presented")
  `BLL_ASSERT_IMP(a_one_op, clk, rst, cmd.do_push, !cmd.do_pop_head,
    "push and pop together")
  `BLL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid,
    "result dropped while stalled")

endmodule
`default_nettype wire

@@ rtl/core/bounded_linked_list_engine_unit.sv @@
// Sequence: decode, the operation's states, front read, back read, result load. Push reads
// the free slot first; pop, contains and remove check each visited slot, a remove past the
// head adds a free-chain step, reverse relinks each slot and clear sweeps every slot.
// One request at a time, the next taken in the cycle after the result loads;
// a stalled result holds the controller until the output register frees.
// Reset: synchronous rst zeroes the pointers and rebuilds the free chain.
`default_nettype none
module bounded_linked_list_engine_unit #(
  parameter int unsigned CAPACITY    = bll_pkg::CapacityDefault,
  parameter int unsigned VALUE_WIDTH = bll_pkg::ValueWidthDefault
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  bll_pkg::request_t in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output bll_pkg::result_t  out_data
);

  bll_pkg::dp_cmd_t    cmd;
  bll_pkg::dp_status_t sts;

  bll_controller u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  bll_datapath #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk, .rst, .req(in_data), .cmd, .sts, .res(out_data)
  );

endmodule
`default_nettype wire
